/* src/ppq_pkg.sv */
// Shared types and constants of the push-out priority packet queue.
package ppq_pkg;

   // Default sizes
   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int NUM_PORTS_DEF   = 4;
   localparam int HANDLE_BITS_DEF = 32;

   // Field widths of the request, response and register ports
   localparam int OP_W       = 1;
   localparam int PORT_FLD_W = 2;
   localparam int HANDLE_W   = 32;
   localparam int SERVICE_W  = 8;
   localparam int STATUS_W   = 3;
   localparam int CSR_W      = 7;

   localparam logic [CSR_W-1:0] THRESHOLD_RESET = 7'd32;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ENQUEUED  = 3'd0,
      ST_NOT_IPV4  = 3'd1,
      ST_SLOW_DROP = 3'd2,
      ST_REPLACED  = 3'd3,
      ST_FULL_DROP = 3'd4,
      ST_DEQUEUED  = 3'd5,
      ST_EMPTY     = 3'd6
   } status_type;

   // Request control bits handed to the queue controller
   typedef struct packed {
      logic   valid;
      op_type op;
      logic   is_ipv4;
      logic   slow;
   } ppq_req_type;

   // Response control bits from the queue controller
   typedef struct packed {
      logic       valid;
      status_type status;
   } ppq_rsp_type;

endpackage

/* src/ppq_ram.sv */
// Simple dual-port RAM, one write and one registered read, write-first on collision.
module ppq_ram #(
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [2**ADDR_W];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, new data wins on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ppq_ctrl.sv */
// Queue controller: per-port pointers, admission decision and RAM addressing.
module ppq_ctrl #(
   parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF,
   parameter int NUM_PORTS   = ppq_pkg::NUM_PORTS_DEF,
   localparam int IDX_W  = $clog2(QUEUE_DEPTH),
   localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1,
   localparam int ADDR_W = PORT_W + IDX_W
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ppq_pkg::ppq_req_type                    req_in,
   input  logic [ppq_pkg::PORT_FLD_W-1:0]          req_port,
   input  logic                                    csr_write,
   input  logic [ppq_pkg::CSR_W-1:0]               csr_data,
   output logic [ADDR_W-1:0]                       slot_rd_addr,
   output logic                                    slot_wr_en,
   output logic [ADDR_W-1:0]                       slot_wr_addr,
   output logic [ADDR_W-1:0]                       slow_rd_addr,
   input  logic [IDX_W-1:0]                        slow_rd_data,
   output logic                                    slow_wr_en,
   output logic [ADDR_W-1:0]                       slow_wr_addr,
   output logic [IDX_W-1:0]                        slow_wr_data,
   output logic                                    deq_take,
   output ppq_pkg::ppq_rsp_type                    rsp
);

   import ppq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PORT_FLD_W:0] NP_NARROW =
      (NUM_PORTS > 3) ? (PORT_FLD_W + 1)'(4) : (PORT_FLD_W + 1)'(NUM_PORTS);

   // circular index add with wrap at the queue depth
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
      if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         s = s - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      return IDX_W'(s);
   endfunction

   ppq_req_type      req_ff;
   logic [PORT_W-1:0] port_ff;
   logic [CSR_W-1:0] thr_ff;
   ppq_rsp_type      rsp_ff;

   logic [IDX_W-1:0] queue_head_ff [NUM_PORTS];
   logic [IDX_W-1:0] queue_head_in [NUM_PORTS];
   logic [CNT_W-1:0] queue_count_ff [NUM_PORTS];
   logic [CNT_W-1:0] queue_count_in [NUM_PORTS];
   logic [IDX_W-1:0] slow_head_ff [NUM_PORTS];
   logic [IDX_W-1:0] slow_head_in [NUM_PORTS];
   logic [CNT_W-1:0] slow_count_ff [NUM_PORTS];
   logic [CNT_W-1:0] slow_count_in [NUM_PORTS];

   logic [PORT_FLD_W-1:0] port_mod;
   logic [PORT_W-1:0]     port_a;
   logic [IDX_W-1:0]      qh;
   logic [CNT_W-1:0]      qc;
   logic [IDX_W-1:0]      sh;
   logic [CNT_W-1:0]      sc;
   logic [CNT_W-1:0]      free_slots;
   logic                  low_space;
   logic [IDX_W-1:0]      append_slot;
   logic [IDX_W-1:0]      slow_pos;
   status_type            status_in;

   // port number folded into range
   always_comb begin
      port_mod = req_port;
      for (int i = 0; i < 3; i++) begin
         if ({1'b0, port_mod} >= NP_NARROW) begin
            port_mod = PORT_FLD_W'({1'b0, port_mod} - NP_NARROW);
         end
      end
      port_a = PORT_W'(port_mod);
   end

   // per-port view of the queued request
   assign qh          = queue_head_ff[port_ff];
   assign qc          = queue_count_ff[port_ff];
   assign sh          = slow_head_ff[port_ff];
   assign sc          = slow_count_ff[port_ff];
   assign free_slots  = DEPTH_CNT - qc;
   assign low_space   = CMP_W'(free_slots) < CMP_W'(thr_ff);
   assign append_slot = wrap_add(qh, qc);
   assign slow_pos    = wrap_add(sh, sc);

   // admission and dequeue decision
   always_comb begin
      queue_head_in  = queue_head_ff;
      queue_count_in = queue_count_ff;
      slow_head_in   = slow_head_ff;
      slow_count_in  = slow_count_ff;
      slot_wr_en     = 1'b0;
      slot_wr_addr   = {port_ff, append_slot};
      slow_wr_en     = 1'b0;
      slow_wr_addr   = {port_ff, slow_pos};
      slow_wr_data   = append_slot;
      deq_take       = 1'b0;
      status_in      = ST_ENQUEUED;
      if (req_ff.valid) begin
         unique case (req_ff.op)
            OP_DEQUEUE: begin
               if (qc == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  deq_take = 1'b1;
                  // retire the side head when it names the head slot
                  if ((sc != '0) && (slow_rd_data == qh)) begin
                     slow_head_in[port_ff]  = wrap_add(sh, CNT_W'(1));
                     slow_count_in[port_ff] = sc - CNT_W'(1);
                  end
                  queue_head_in[port_ff]  = wrap_add(qh, CNT_W'(1));
                  queue_count_in[port_ff] = qc - CNT_W'(1);
                  status_in = ST_DEQUEUED;
               end
            end
            OP_ENQUEUE: begin
               priority if (!req_ff.is_ipv4) begin
                  status_in = ST_NOT_IPV4;
               end else if (low_space && req_ff.slow) begin
                  status_in = ST_SLOW_DROP;
               end else if (low_space && (sc != '0)) begin
                  // push out the oldest slow entry
                  slot_wr_en             = 1'b1;
                  slot_wr_addr           = {port_ff, slow_rd_data};
                  slow_head_in[port_ff]  = wrap_add(sh, CNT_W'(1));
                  slow_count_in[port_ff] = sc - CNT_W'(1);
                  status_in = ST_REPLACED;
               end else if (qc < DEPTH_CNT) begin
                  slot_wr_en              = 1'b1;
                  queue_count_in[port_ff] = qc + CNT_W'(1);
                  if (!low_space && req_ff.slow && (sc < DEPTH_CNT)) begin
                     slow_wr_en             = 1'b1;
                     slow_count_in[port_ff] = sc + CNT_W'(1);
                  end
                  status_in = ST_ENQUEUED;
               end else begin
                  status_in = ST_FULL_DROP;
               end
            end
            default: begin
               status_in = ST_ENQUEUED;
            end
         endcase
      end
   end

   // RAM reads for the incoming request see this cycle's pointer updates
   assign slot_rd_addr = {port_a, queue_head_in[port_a]};
   assign slow_rd_addr = {port_a, slow_head_in[port_a]};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PORTS; i++) begin
            queue_head_ff[i]  <= '0;
            queue_count_ff[i] <= '0;
            slow_head_ff[i]   <= '0;
            slow_count_ff[i]  <= '0;
         end
         thr_ff <= THRESHOLD_RESET;
         req_ff <= '0;
         rsp_ff <= '0;
      end else begin
         queue_head_ff  <= queue_head_in;
         queue_count_ff <= queue_count_in;
         slow_head_ff   <= slow_head_in;
         slow_count_ff  <= slow_count_in;
         if (csr_write) begin
            thr_ff <= csr_data;
         end
         req_ff <= req_in;
         rsp_ff <= '{valid: req_ff.valid, status: status_in};
      end
   end

   // port of the request in flight
   always_ff @(posedge clock) begin
      if (req_in.valid) begin
         port_ff <= port_a;
      end
   end

   assign rsp = rsp_ff;

endmodule

/* src/pushout_priority_packet_queue_unit.sv */
// Top level of the push-out priority packet queue.
//
// Per-port FIFO of packet handles with push-out admission for fast packets.
// Request channel: a request (enqueue or dequeue on req_port) is taken at a
// rising edge where start is high and busy is low. busy stays low, so one
// request can be issued in every cycle.
// Response channel: every request yields one response. rsp_strobe marks it
// for one cycle, carrying rsp_status and rsp_out_handle (zero unless dequeued).
// Timing: the handle and side-index RAMs are read at the acceptance edge,
// where the request is also registered; the decision is made from the
// registered request, and the pointer and RAM updates and the response
// register all load together.
// Throughput: one request per cycle, set by the pointer updates feeding the
// RAM read addresses and the RAM read bypass of a same-cycle write.
// Register port: csr_space_threshold is written when csr_valid is high;
// csr_ready is always high. Write it only while no request is in flight.
// Reset: synchronous; empties every queue and sets the threshold to 32.
// RAM contents are not cleared. The receiver cannot stall responses.
module pushout_priority_packet_queue_unit #(
   parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF,
   parameter int NUM_PORTS   = ppq_pkg::NUM_PORTS_DEF,
   parameter int HANDLE_BITS = ppq_pkg::HANDLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ppq_pkg::OP_W-1:0]          req_operation,
   input  logic [ppq_pkg::PORT_FLD_W-1:0]    req_port,
   input  logic [ppq_pkg::HANDLE_W-1:0]      req_packet_handle,
   input  logic                              req_is_ipv4,
   input  logic [ppq_pkg::SERVICE_W-1:0]     req_service_type,
   output logic                              rsp_strobe,
   output logic [ppq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ppq_pkg::HANDLE_W-1:0]      rsp_out_handle,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ppq_pkg::CSR_W-1:0]         csr_space_threshold
);

   import ppq_pkg::*;

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam int ADDR_W = PORT_W + IDX_W;
   localparam int HBITS  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

   logic              req_accept;
   ppq_req_type       req_ctl;
   ppq_rsp_type       rsp_ctl;
   logic [HBITS-1:0]  handle_ff;
   logic [HANDLE_W-1:0] out_handle_ff;

   logic [ADDR_W-1:0] slot_rd_addr;
   logic              slot_wr_en;
   logic [ADDR_W-1:0] slot_wr_addr;
   logic [HBITS-1:0]  slot_rd_data;
   logic [ADDR_W-1:0] slow_rd_addr;
   logic [IDX_W-1:0]  slow_rd_data;
   logic              slow_wr_en;
   logic [ADDR_W-1:0] slow_wr_addr;
   logic [IDX_W-1:0]  slow_wr_data;
   logic              deq_take;

   assign busy       = 1'b0;
   assign csr_ready  = 1'b1;
   assign req_accept = start && !busy;

   // request control bits
   always_comb begin
      req_ctl.valid   = req_accept;
      req_ctl.op      = op_type'(req_operation);
      req_ctl.is_ipv4 = req_is_ipv4;
      req_ctl.slow    = (req_service_type == '0);
   end

   // handle of the request in flight
   always_ff @(posedge clock) begin
      if (req_accept) begin
         handle_ff <= req_packet_handle[HBITS-1:0];
      end
   end

   ppq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .NUM_PORTS   (NUM_PORTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_in       (req_ctl),
      .req_port     (req_port),
      .csr_write    (csr_valid && csr_ready),
      .csr_data     (csr_space_threshold),
      .slot_rd_addr (slot_rd_addr),
      .slot_wr_en   (slot_wr_en),
      .slot_wr_addr (slot_wr_addr),
      .slow_rd_addr (slow_rd_addr),
      .slow_rd_data (slow_rd_data),
      .slow_wr_en   (slow_wr_en),
      .slow_wr_addr (slow_wr_addr),
      .slow_wr_data (slow_wr_data),
      .deq_take     (deq_take),
      .rsp          (rsp_ctl)
   );

   // packet handle store
   ppq_ram #(
      .WIDTH  (HBITS),
      .ADDR_W (ADDR_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (handle_ff),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   // slot indices of queued slow packets
   ppq_ram #(
      .WIDTH  (IDX_W),
      .ADDR_W (ADDR_W)
   ) u_slow_ram (
      .clock   (clock),
      .wr_en   (slow_wr_en),
      .wr_addr (slow_wr_addr),
      .wr_data (slow_wr_data),
      .rd_addr (slow_rd_addr),
      .rd_data (slow_rd_data)
   );

   // response handle register
   always_ff @(posedge clock) begin
      out_handle_ff <= deq_take ? HANDLE_W'(slot_rd_data) : '0;
   end

   assign rsp_strobe     = rsp_ctl.valid;
   assign rsp_status     = rsp_ctl.status;
   assign rsp_out_handle = out_handle_ff;

endmodule

/* dv/tb.sv */
// Self-checking testbench for the push-out priority packet queue unit.
`timescale 1ns / 100ps

module tb;
   import ppq_pkg::*;

   localparam int DEPTH          = QUEUE_DEPTH_DEF;
   localparam int NUM_PORTS      = NUM_PORTS_DEF;
   localparam int RESET_CYCLES   = 6;
   localparam int SETTLE_CYCLES  = 5;
   localparam int WATCHDOG_LIMIT = 200;
   localparam int PHASES         = 7;
   localparam int PHASE_ITEMS    = 120;

   typedef enum logic [1:0] {
      JOB_REQ   = 2'd0,
      JOB_CSR   = 2'd1,
      JOB_DRAIN = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      op_type       op;
      logic [1:0]   port;
      logic [31:0]  handle;
      logic         ipv4;
      logic [7:0]   tos;
      logic [6:0]   thr;
   } stim_job_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] handle;
   } queue_rsp_type;

   // DUT signals
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [0:0]  req_operation = '0;
   logic [1:0]  req_port = '0;
   logic [31:0] req_packet_handle = '0;
   logic        req_is_ipv4 = 1'b0;
   logic [7:0]  req_service_type = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_out_handle;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_space_threshold = '0;

   // Stimulus and scoreboard state
   stim_job_type  stim_jobs [$];
   queue_rsp_type pending_rsp [$];
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   logic stim_done = 1'b0;
   int   quiet_cycles = 0;
   int   gap_left = 0;
   int   burst_left = 1;
   int   idle_cycles = 0;
   int   errors = 0;

   // Predicted queue state, per port
   logic [31:0] slot_mem [NUM_PORTS][DEPTH];
   logic [5:0]  slow_mem [NUM_PORTS][DEPTH];
   logic [5:0]  q_head   [NUM_PORTS];
   logic [6:0]  q_cnt    [NUM_PORTS];
   logic [5:0]  slow_hd  [NUM_PORTS];
   logic [6:0]  slow_cnt [NUM_PORTS];
   logic [6:0]  thr_model = THRESHOLD_RESET;

   pushout_priority_packet_queue_unit dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_port            (req_port),
      .req_packet_handle   (req_packet_handle),
      .req_is_ipv4         (req_is_ipv4),
      .req_service_type    (req_service_type),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_out_handle      (rsp_out_handle),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_space_threshold (csr_space_threshold)
   );

   always #1 clock = ~clock;

   // Admission and dequeue decision for one request; updates predicted state
   task automatic queue_predict(input op_type op, input logic [1:0] port,
                                input logic [31:0] handle, input logic ipv4,
                                input logic [7:0] tos, output queue_rsp_type rsp);
      int         p;
      logic       slow;
      logic [5:0] hs;
      logic [5:0] slot;
      p = int'(port) % NUM_PORTS;
      slow = (tos == 8'd0);
      rsp.handle = '0;
      if (op == OP_DEQUEUE) begin
         if (q_cnt[p] == 0) begin
            rsp.status = ST_EMPTY;
         end else begin
            hs = q_head[p];
            rsp.handle = slot_mem[p][hs];
            // oldest slow entry leaves with the head when it is the same slot
            if (slow_cnt[p] != 0 && slow_mem[p][slow_hd[p]] == hs) begin
               slow_hd[p] = slow_hd[p] + 6'd1;
               slow_cnt[p] = slow_cnt[p] - 7'd1;
            end
            q_head[p] = hs + 6'd1;
            q_cnt[p] = q_cnt[p] - 7'd1;
            rsp.status = ST_DEQUEUED;
         end
      end else if (!ipv4) begin
         rsp.status = ST_NOT_IPV4;
      end else if ((DEPTH - int'(q_cnt[p])) < int'(thr_model)) begin
         // low space: slow drops; fast pushes out the oldest slow entry, if any
         if (slow) begin
            rsp.status = ST_SLOW_DROP;
         end else if (slow_cnt[p] != 0) begin
            slot_mem[p][slow_mem[p][slow_hd[p]]] = handle;
            slow_hd[p] = slow_hd[p] + 6'd1;
            slow_cnt[p] = slow_cnt[p] - 7'd1;
            rsp.status = ST_REPLACED;
         end else if (q_cnt[p] < DEPTH) begin
            slot = q_head[p] + q_cnt[p][5:0];
            slot_mem[p][slot] = handle;
            q_cnt[p] = q_cnt[p] + 7'd1;
            rsp.status = ST_ENQUEUED;
         end else begin
            rsp.status = ST_FULL_DROP;
         end
      end else if (q_cnt[p] < DEPTH) begin
         slot = q_head[p] + q_cnt[p][5:0];
         slot_mem[p][slot] = handle;
         q_cnt[p] = q_cnt[p] + 7'd1;
         if (slow && slow_cnt[p] < DEPTH) begin
            slow_mem[p][slow_hd[p] + slow_cnt[p][5:0]] = slot;
            slow_cnt[p] = slow_cnt[p] + 7'd1;
         end
         rsp.status = ST_ENQUEUED;
      end else begin
         rsp.status = ST_FULL_DROP;
      end
   endtask

   task automatic add_req(input op_type op, input logic [1:0] port,
                          input logic [31:0] handle, input logic ipv4,
                          input logic [7:0] tos);
      stim_job_type j;
      j = '{kind: JOB_REQ, op: op, port: port, handle: handle, ipv4: ipv4,
            tos: tos, thr: '0};
      stim_jobs.push_back(j);
   endtask

   task automatic add_ctrl(input job_kind_type kind, input logic [6:0] thr);
      stim_job_type j;
      j = '{kind: kind, op: OP_ENQUEUE, port: '0, handle: '0, ipv4: 1'b0,
            tos: '0, thr: thr};
      stim_jobs.push_back(j);
   endtask

   // Driver: changes inputs on the falling edge, bursts with random gaps
   always @(negedge clock) begin
      stim_job_type j;
      logic         n_start;
      logic         n_csr;
      n_start = start && !req_taken;
      n_csr = csr_valid && !csr_taken;
      if (!reset) begin
         if (pending_rsp.size() == 0 && !n_start) quiet_cycles <= quiet_cycles + 1;
         else quiet_cycles <= 0;
         if (!n_start && !n_csr && stim_jobs.size() != 0) begin
            j = stim_jobs[0];
            if (j.kind == JOB_REQ) begin
               if (gap_left != 0) begin
                  gap_left <= gap_left - 1;
               end else begin
                  j = stim_jobs.pop_front();
                  req_operation <= j.op;
                  req_port <= j.port;
                  req_packet_handle <= j.handle;
                  req_is_ipv4 <= j.ipv4;
                  req_service_type <= j.tos;
                  n_start = 1'b1;
                  if (burst_left <= 1) begin
                     burst_left <= $urandom_range(1, 40);
                     gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                  end else begin
                     burst_left <= burst_left - 1;
                  end
               end
            end else if (quiet_cycles >= SETTLE_CYCLES) begin
               // register writes and pauses wait for an idle block
               j = stim_jobs.pop_front();
               if (j.kind == JOB_CSR) begin
                  csr_space_threshold <= j.thr;
                  n_csr = 1'b1;
               end
            end
         end
      end
      stim_done <= (stim_jobs.size() == 0) && !n_start && !n_csr && !reset;
      start <= n_start;
      csr_valid <= n_csr;
   end

   // Monitor: samples on the rising edge, checks responses, predicts requests
   always @(posedge clock) begin
      queue_rsp_type want;
      queue_rsp_type got;
      req_taken <= !reset && start && !busy;
      csr_taken <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected response, status %0d handle %h",
                        $time, rsp_status, rsp_out_handle);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  errors++;
               end
               if (rsp_out_handle !== want.handle) begin
                  $display("%0t: out_handle expected %h actual %h",
                           $time, want.handle, rsp_out_handle);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) thr_model = csr_space_threshold;
         if (start && !busy) begin
            queue_predict(op_type'(req_operation), req_port, req_packet_handle,
                          req_is_ipv4, req_service_type, got);
            pending_rsp.push_back(got);
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      int     phase_thr [PHASES];
      int     phase_enq [PHASES];
      int     focus;
      op_type op;
      logic [1:0] port;
      logic [7:0] tos;
      for (int p = 0; p < NUM_PORTS; p++) begin
         q_head[p] = '0;
         q_cnt[p] = '0;
         slow_hd[p] = '0;
         slow_cnt[p] = '0;
      end

      // Directed: empty dequeue with junk fields, non-IPv4, slow and fast,
      // handle extremes, side FIFO retire on dequeue, every port
      add_req(OP_DEQUEUE, 2'd0, 32'hFFFF_FFFF, 1'b1, 8'hFF);
      add_req(OP_ENQUEUE, 2'd0, 32'hFFFF_FFFF, 1'b0, 8'h00);
      add_req(OP_ENQUEUE, 2'd0, 32'h0000_0000, 1'b1, 8'h00);
      add_req(OP_ENQUEUE, 2'd0, 32'hFFFF_FFFF, 1'b1, 8'hFF);
      add_req(OP_ENQUEUE, 2'd0, 32'hA5A5_A5A5, 1'b1, 8'h01);
      add_req(OP_DEQUEUE, 2'd0, 32'h0000_0000, 1'b0, 8'h00);
      add_req(OP_DEQUEUE, 2'd0, 32'h1234_5678, 1'b1, 8'h80);
      add_req(OP_DEQUEUE, 2'd0, 32'h0000_0000, 1'b0, 8'h00);
      add_req(OP_DEQUEUE, 2'd0, 32'h0000_0000, 1'b0, 8'h00);
      add_req(OP_ENQUEUE, 2'd1, 32'h5A5A_5A5A, 1'b1, 8'h00);
      add_req(OP_ENQUEUE, 2'd2, 32'h8000_0001, 1'b1, 8'h7F);
      add_req(OP_ENQUEUE, 2'd3, 32'h7FFF_FFFE, 1'b1, 8'h00);
      add_req(OP_ENQUEUE, 2'd3, 32'hDEAD_BEEF, 1'b0, 8'h55);
      add_req(OP_DEQUEUE, 2'd3, 32'hFFFF_FFFF, 1'b0, 8'hFF);
      add_req(OP_DEQUEUE, 2'd2, 32'h0000_0000, 1'b1, 8'h00);
      add_req(OP_DEQUEUE, 2'd1, 32'h0000_0000, 1'b1, 8'h00);
      add_req(OP_DEQUEUE, 2'd1, 32'h0000_0000, 1'b1, 8'h00);

      // Random phases: zero threshold, threshold at and near depth, tiny,
      // mid and random; fill-heavy and drain-heavy mixes on a focus port
      phase_thr = '{0, 64, 63, 1, 48, 0, 32};
      phase_thr[5] = $urandom_range(0, 64);
      phase_enq = '{90, 90, 30, 90, 30, 85, 60};
      for (int ph = 0; ph < PHASES; ph++) begin
         add_ctrl(JOB_CSR, 7'(phase_thr[ph]));
         focus = $urandom_range(0, NUM_PORTS - 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold off until the queue has answered everything
            if (i == PHASE_ITEMS / 2) add_ctrl(JOB_DRAIN, '0);
            op = ($urandom_range(0, 99) < phase_enq[ph]) ? OP_ENQUEUE : OP_DEQUEUE;
            port = ($urandom_range(0, 99) < 80) ? 2'(focus) : 2'($urandom_range(0, 3));
            tos = ($urandom_range(0, 99) < 40) ? 8'd0 : 8'($urandom_range(1, 255));
            add_req(op, port, $urandom, $urandom_range(0, 99) < 94, tos);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (stim_done);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

/* pushout_priority_packet_queue_unit.f */
src/ppq_pkg.sv
src/ppq_ram.sv
src/ppq_ctrl.sv
src/pushout_priority_packet_queue_unit.sv
dv/tb.sv
